// ===== sv/psr_pkg.sv =====
// Package for the P-256 Solinas reduction core: shared types, widths and constants.
// No dependencies; every other file but psr_channel_if imports it.
package psr_pkg;

   localparam int WORD_W  = 64;
   localparam int LIMB_W  = 32;
   localparam int NUM_COL = 8;
   localparam int COL_W   = 36;
   localparam int SUM_W   = 264;
   localparam int FOLD_W  = 258;

   typedef logic [7:0][WORD_W-1:0] wide_type;
   typedef logic [3:0][WORD_W-1:0] narrow_type;
   typedef logic signed [COL_W-1:0] col_type;
   typedef col_type cols_type [0:NUM_COL-1];
   typedef logic signed [SUM_W-1:0] sum_type;
   typedef logic signed [FOLD_W-1:0] fold_type;

   // p = 2^256 - 2^224 + 2^192 + 2^96 - 1
   localparam logic [255:0] PRIME =
      256'hFFFFFFFF_00000001_00000000_00000000_00000000_FFFFFFFF_FFFFFFFF_FFFFFFFF;

   // 4p split into 32-bit limbs, low first; the ninth limb (3) is in TOP_BIAS
   localparam col_type BIAS4P [0:NUM_COL-1] = '{
      36'sh0FFFFFFFC, 36'sh0FFFFFFFF, 36'sh0FFFFFFFF, 36'sh000000003,
      36'sh000000000, 36'sh000000000, 36'sh000000004, 36'sh0FFFFFFFC
   };

   localparam logic [SUM_W-1:0] TOP_BIAS =
      264'h03_00000000_00000000_00000000_00000000_00000000_00000000_00000000_00000000;

   // column carries travel offset by 8 in each 4-bit slot; this removes the offset
   localparam logic [SUM_W-1:0] SLOT_OFFSET =
      264'h08_00000008_00000008_00000008_00000008_00000008_00000008_00000008_00000000;

endpackage

// ===== sv/psr_channel_if.sv =====
// Valid/ready channel interfaces for requests and responses of the reduction core.
// No dependencies.
interface psr_req_if;
   logic        valid;
   logic        ready;
   logic [63:0] wide_word0;
   logic [63:0] wide_word1;
   logic [63:0] wide_word2;
   logic [63:0] wide_word3;
   logic [63:0] wide_word4;
   logic [63:0] wide_word5;
   logic [63:0] wide_word6;
   logic [63:0] wide_word7;

   modport source (
      output valid, wide_word0, wide_word1, wide_word2, wide_word3,
             wide_word4, wide_word5, wide_word6, wide_word7,
      input  ready
   );
   modport sink (
      input  valid, wide_word0, wide_word1, wide_word2, wide_word3,
             wide_word4, wide_word5, wide_word6, wide_word7,
      output ready
   );
endinterface

interface psr_rsp_if;
   logic        valid;
   logic        ready;
   logic [63:0] reduced_word0;
   logic [63:0] reduced_word1;
   logic [63:0] reduced_word2;
   logic [63:0] reduced_word3;

   modport source (
      output valid, reduced_word0, reduced_word1, reduced_word2, reduced_word3,
      input  ready
   );
   modport sink (
      input  valid, reduced_word0, reduced_word1, reduced_word2, reduced_word3,
      output ready
   );
endinterface

// ===== sv/psr_columns.sv =====
// Column sums of the P-256 reduction identity, each biased by a limb of 4p.
// Depends on psr_pkg.
module psr_columns
   import psr_pkg::*;
(
   input  wide_type words,
   output cols_type cols
);

   col_type x [0:15];

   always_comb begin
      for (int k = 0; k < 16; k++) begin
         x[k] = $signed({4'b0000, words[k >> 1][(k & 1) * LIMB_W +: LIMB_W]});
      end
   end

   always_comb begin
      cols[0] = BIAS4P[0] + x[0] + x[8] + x[9] - (x[11] + x[12] + x[13] + x[14]);
      cols[1] = BIAS4P[1] + x[1] + x[9] + x[10] - (x[12] + x[13] + x[14] + x[15]);
      cols[2] = BIAS4P[2] + x[2] + x[10] + x[11] - (x[13] + x[14] + x[15]);
      cols[3] = BIAS4P[3] + x[3] + ((x[11] + x[12]) <<< 1) + x[13]
                - (x[15] + x[8] + x[9]);
      cols[4] = BIAS4P[4] + x[4] + ((x[12] + x[13]) <<< 1) + x[14] - (x[9] + x[10]);
      cols[5] = BIAS4P[5] + x[5] + ((x[13] + x[14]) <<< 1) + x[15] - (x[10] + x[11]);
      cols[6] = BIAS4P[6] + x[6] + x[13] + x[14] + (x[14] <<< 1) + (x[15] <<< 1)
                - (x[8] + x[9]);
      cols[7] = BIAS4P[7] + x[7] + x[15] + (x[15] <<< 1) + x[8]
                - (x[10] + x[11] + x[12] + x[13]);
   end

endmodule

// ===== sv/psr_carry.sv =====
// Resolves the overlapping column sums into one signed 264-bit total.
// Depends on psr_pkg.
module psr_carry
   import psr_pkg::*;
(
   input  cols_type cols,
   output sum_type  total
);

   logic [SUM_W-1:0] low_bits;
   logic [SUM_W-1:0] carry_bits;

   // each column carry lies in -4..7, held as carry+8 (top bit flipped)
   always_comb begin
      low_bits   = '0;
      carry_bits = '0;
      for (int k = 0; k < NUM_COL; k++) begin
         low_bits[k * LIMB_W +: LIMB_W]       = cols[k][LIMB_W-1:0];
         carry_bits[(k + 1) * LIMB_W +: 4]    = {~cols[k][COL_W-1], cols[k][COL_W-2:LIMB_W]};
      end
   end

   assign total = $signed(low_bits + carry_bits + TOP_BIAS - SLOT_OFFSET);

endmodule

// ===== sv/psr_fold.sv =====
// Folds the bits above 2^256 back in: low + top*(2^256 - p).
// Depends on psr_pkg.
module psr_fold
   import psr_pkg::*;
(
   input  sum_type  total,
   output fold_type folded
);

   logic signed [7:0] top;
   fold_type          top_ext;

   assign top     = total[SUM_W-1:256];
   assign top_ext = {{(FOLD_W-8){top[7]}}, top};

   // 2^256 - p = 2^224 - 2^192 - 2^96 + 1
   assign folded = $signed({2'b00, total[255:0]}) + (top_ext <<< 224)
                   - (top_ext <<< 192) - (top_ext <<< 96) + top_ext;

endmodule

// ===== sv/psr_final.sv =====
// Final correction of a value in (-p, 2p) into [0, p).
// Depends on psr_pkg.
module psr_final
   import psr_pkg::*;
(
   input  fold_type   folded,
   output narrow_type reduced
);

   fold_type     plus_p;
   fold_type     minus_p;
   logic [255:0] result;

   assign plus_p  = folded + $signed({2'b00, PRIME});
   assign minus_p = folded - $signed({2'b00, PRIME});

   always_comb begin
      if (folded[FOLD_W-1]) begin
         result = plus_p[255:0];
      end else if (!minus_p[FOLD_W-1]) begin
         result = minus_p[255:0];
      end else begin
         result = folded[255:0];
      end
   end

   always_comb begin
      for (int k = 0; k < 4; k++) begin
         reduced[k] = result[k * WORD_W +: WORD_W];
      end
   end

endmodule

// ===== sv/p256_solinas_reduction_core.sv =====
// Top level of the P-256 fast modular reduction core.
// Depends on psr_pkg, psr_channel_if, psr_columns, psr_carry, psr_fold, psr_final.
//
// Usage:
//   req_ch carries a 512-bit value as eight 64-bit words, least significant first.
//   rsp_ch returns that value modulo the P-256 prime as four 64-bit words.
//   Both channels are valid/ready; a request moves when valid and ready are high
//   at a rising clock edge. Every request yields exactly one response, in order.
// Throughput: one request per cycle, sustained while rsp_ch.ready stays high.
// Pipeline: the request lands in the input register at the accepting edge, then
//   passes four arithmetic stages (column sums, carry resolve, fold of the top
//   carry, final correction), each ending in a register; rsp_ch.valid rises
//   when the request reaches the last of them.
// Stalls: each stage holds while it is full and the next cannot load; a bubble
//   anywhere lets the front keep taking requests, so req_ch.ready stays high
//   while a finished response waits, as long as the pipeline has an empty slot.
// Reset: synchronous, active high; all pipeline valid bits clear, no response
//   is pending afterwards. Data registers are not reset.
module p256_solinas_reduction_core
   import psr_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   psr_req_if.sink       req_ch,
   psr_rsp_if.source     rsp_ch
);

   logic       in_vld_ff,  in_vld_in;
   logic       col_vld_ff, col_vld_in;
   logic       sum_vld_ff, sum_vld_in;
   logic       fld_vld_ff, fld_vld_in;
   logic       out_vld_ff, out_vld_in;

   logic       adv_in, adv_col, adv_sum, adv_fld, adv_out;

   wide_type   words_ff,   words_in;
   cols_type   cols_ff,    cols_in;
   sum_type    total_ff,   total_in;
   fold_type   folded_ff,  folded_in;
   narrow_type reduced_ff, reduced_in;

   // a stage may load when it is empty or its contents move on this cycle
   assign adv_out = !out_vld_ff || rsp_ch.ready;
   assign adv_fld = !fld_vld_ff || adv_out;
   assign adv_sum = !sum_vld_ff || adv_fld;
   assign adv_col = !col_vld_ff || adv_sum;
   assign adv_in  = !in_vld_ff  || adv_col;

   assign req_ch.ready = adv_in;

   assign in_vld_in  = adv_in  ? req_ch.valid : in_vld_ff;
   assign col_vld_in = adv_col ? in_vld_ff    : col_vld_ff;
   assign sum_vld_in = adv_sum ? col_vld_ff   : sum_vld_ff;
   assign fld_vld_in = adv_fld ? sum_vld_ff   : fld_vld_ff;
   assign out_vld_in = adv_out ? fld_vld_ff   : out_vld_ff;

   assign words_in[0] = req_ch.wide_word0;
   assign words_in[1] = req_ch.wide_word1;
   assign words_in[2] = req_ch.wide_word2;
   assign words_in[3] = req_ch.wide_word3;
   assign words_in[4] = req_ch.wide_word4;
   assign words_in[5] = req_ch.wide_word5;
   assign words_in[6] = req_ch.wide_word6;
   assign words_in[7] = req_ch.wide_word7;

   psr_columns u_columns (
      .words (words_ff),
      .cols  (cols_in)
   );

   psr_carry u_carry (
      .cols  (cols_ff),
      .total (total_in)
   );

   psr_fold u_fold (
      .total  (total_ff),
      .folded (folded_in)
   );

   psr_final u_final (
      .folded  (folded_ff),
      .reduced (reduced_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff  <= 1'b0;
         col_vld_ff <= 1'b0;
         sum_vld_ff <= 1'b0;
         fld_vld_ff <= 1'b0;
         out_vld_ff <= 1'b0;
      end else begin
         in_vld_ff  <= in_vld_in;
         col_vld_ff <= col_vld_in;
         sum_vld_ff <= sum_vld_in;
         fld_vld_ff <= fld_vld_in;
         out_vld_ff <= out_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (adv_in) begin
         words_ff <= words_in;
      end
      if (adv_col) begin
         cols_ff <= cols_in;
      end
      if (adv_sum) begin
         total_ff <= total_in;
      end
      if (adv_fld) begin
         folded_ff <= folded_in;
      end
      if (adv_out) begin
         reduced_ff <= reduced_in;
      end
   end

   assign rsp_ch.valid         = out_vld_ff;
   assign rsp_ch.reduced_word0 = reduced_ff[0];
   assign rsp_ch.reduced_word1 = reduced_ff[1];
   assign rsp_ch.reduced_word2 = reduced_ff[2];
   assign rsp_ch.reduced_word3 = reduced_ff[3];

endmodule

// ===== sv/psr_checker.sv =====
// Port-level checks for the reduction core, attached to the top level by bind.
// Depends on psr_pkg, psr_channel_if, p256_solinas_reduction_core.
module psr_checker
   import psr_pkg::*;
(
   input logic       clock,
   input logic       reset,
   psr_req_if.sink   req_ch,
   psr_rsp_if.source rsp_ch
);

   // a pending response stays up until taken
   ast_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid && !rsp_ch.ready |=> rsp_ch.valid)
      else $error("response dropped while stalled");

   // a stalled response keeps its data
   ast_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid && !rsp_ch.ready |=>
         $stable(rsp_ch.reduced_word0) && $stable(rsp_ch.reduced_word1) &&
         $stable(rsp_ch.reduced_word2) && $stable(rsp_ch.reduced_word3))
      else $error("response data changed while stalled");

   // every result is fully reduced
   ast_reduced: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid |-> ({rsp_ch.reduced_word3, rsp_ch.reduced_word2,
                         rsp_ch.reduced_word1, rsp_ch.reduced_word0} < PRIME))
      else $error("result not below p");

   // reset empties the pipeline
   ast_reset_clear: assert property (@(posedge clock)
      reset |=> !rsp_ch.valid)
      else $error("response pending after reset");

   // with no response waiting nothing can back up, so requests are taken
   ast_ready_free: assert property (@(posedge clock) disable iff (reset)
      !rsp_ch.valid |-> req_ch.ready)
      else $error("request refused with empty output");

endmodule

bind p256_solinas_reduction_core psr_checker u_psr_checker (
   .clock  (clock),
   .reset  (reset),
   .req_ch (req_ch),
   .rsp_ch (rsp_ch)
);

// ===== bench/p256_reduction_checker.sv =====
// Response checker for the P-256 reduction core: predicts each residue and compares.
// Depends on psr_pkg and psr_channel_if.
module p256_reduction_checker
   import psr_pkg::*;
(
   input  logic  clock,
   input  logic  reset,
   psr_req_if    req_mon,
   psr_rsp_if    rsp_mon,
   output int    error_count,
   output int    expected_left
);

   narrow_type expected_rsp [$];

   // Solinas column sums taken as exact signed integers, then brought into [0, p)
   function automatic narrow_type reduce_p256(input wide_type value);
      longint x [16];
      longint col [8];
      logic signed [319:0] acc;
      logic signed [319:0] term;
      logic signed [319:0] prime_s;
      prime_s = {64'd0, PRIME};
      for (int k = 0; k < 16; k++) begin
         x[k] = longint'(value[k >> 1][32 * (k & 1) +: 32]);
      end
      col[0] = x[0] + x[8] + x[9] - (x[11] + x[12] + x[13] + x[14]);
      col[1] = x[1] + x[9] + x[10] - (x[12] + x[13] + x[14] + x[15]);
      col[2] = x[2] + x[10] + x[11] - (x[13] + x[14] + x[15]);
      col[3] = x[3] + 2 * (x[11] + x[12]) + x[13] - (x[15] + x[8] + x[9]);
      col[4] = x[4] + 2 * (x[12] + x[13]) + x[14] - (x[9] + x[10]);
      col[5] = x[5] + 2 * (x[13] + x[14]) + x[15] - (x[10] + x[11]);
      col[6] = x[6] + x[13] + 3 * x[14] + 2 * x[15] - (x[8] + x[9]);
      col[7] = x[7] + 3 * x[15] + x[8] - (x[10] + x[11] + x[12] + x[13]);
      acc = '0;
      for (int k = 0; k < 8; k++) begin
         term = col[k];
         acc = acc + (term <<< (32 * k));
      end
      // sum lies within a few multiples of p either side of zero
      while (acc < 0) acc = acc + prime_s;
      while (acc >= prime_s) acc = acc - prime_s;
      return narrow_type'(acc[255:0]);
   endfunction

   always @(posedge clock) begin
      narrow_type seen;
      narrow_type want;
      if (reset) begin
         error_count <= 0;
         expected_rsp.delete();
      end else begin
         if (req_mon.valid && req_mon.ready) begin
            expected_rsp.push_back(reduce_p256({req_mon.wide_word7, req_mon.wide_word6,
                                                req_mon.wide_word5, req_mon.wide_word4,
                                                req_mon.wide_word3, req_mon.wide_word2,
                                                req_mon.wide_word1, req_mon.wide_word0}));
         end
         if (rsp_mon.valid && rsp_mon.ready) begin
            seen = {rsp_mon.reduced_word3, rsp_mon.reduced_word2,
                    rsp_mon.reduced_word1, rsp_mon.reduced_word0};
            if (expected_rsp.size() == 0) begin
               $error("response with no request outstanding: %h", seen);
               error_count <= error_count + 1;
            end else begin
               want = expected_rsp.pop_front();
               if (want != seen) begin
                  for (int k = 0; k < 4; k++) begin
                     if (want[k] != seen[k]) begin
                        $error("reduced_word%0d: expected %h, actual %h", k, want[k], seen[k]);
                     end
                  end
                  error_count <= error_count + 1;
               end
            end
         end
      end
      expected_left <= expected_rsp.size();
   end

endmodule

// ===== bench/p256_solinas_reduction_core_test.sv =====
// Top of the P-256 reduction core bench: clock, reset, request stimulus, response stalls.
// Depends on psr_pkg, psr_channel_if, p256_reduction_checker and the core itself.
module p256_solinas_reduction_core_test;
   import psr_pkg::*;

   localparam int RANDOM_COUNT = 750;
   localparam int HOLD_AT      = 180;
   localparam int DRAIN_AT     = 420;
   localparam int LONG_HOLD    = 60;
   localparam int IDLE_LIMIT   = 600;
   localparam int TAIL_CYCLES  = 12;

   logic clock = 1'b0;
   logic reset = 1'b1;

   int error_count;
   int expected_left;
   int sent_count = 0;
   int done_count = 0;
   int idle_cycles = 0;
   int hold_requests = 0;

   psr_req_if req_ch ();
   psr_rsp_if rsp_ch ();

   p256_solinas_reduction_core DUT (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   p256_reduction_checker checker_i (
      .clock         (clock),
      .reset         (reset),
      .req_mon       (req_ch),
      .rsp_mon       (rsp_ch),
      .error_count   (error_count),
      .expected_left (expected_left)
   );

   always #10 clock = ~clock;

   always @(posedge clock) begin
      if (req_ch.valid && req_ch.ready) sent_count <= sent_count + 1;
      if (rsp_ch.valid && rsp_ch.ready) done_count <= done_count + 1;
      if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) || reset) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles == IDLE_LIMIT) begin
         $display("status: fail");
         $finish;
      end
   end

   function automatic logic [255:0] random_residue();
      logic [255:0] r;
      r = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
      if (r >= PRIME) r = r - PRIME;
      return r;
   endfunction

   function automatic wide_type random_request();
      wide_type v;
      logic [255:0] a;
      logic [255:0] b;
      int pick;
      pick = $urandom_range(0, 99);
      a = random_residue();
      b = random_residue();
      if (pick < 40) begin
         // product of two residues, the usual caller
         v = {256'd0, a} * {256'd0, b};
      end else if (pick < 60) begin
         for (int k = 0; k < 16; k++) v[k >> 1][32 * (k & 1) +: 32] = $urandom;
      end else if (pick < 75) begin
         for (int k = 0; k < 16; k++) begin
            case ($urandom_range(0, 4))
               0:       v[k >> 1][32 * (k & 1) +: 32] = 32'h0;
               1:       v[k >> 1][32 * (k & 1) +: 32] = 32'hFFFFFFFF;
               2:       v[k >> 1][32 * (k & 1) +: 32] = 32'h1;
               3:       v[k >> 1][32 * (k & 1) +: 32] = 32'h80000000;
               default: v[k >> 1][32 * (k & 1) +: 32] = $urandom;
            endcase
         end
      end else if (pick < 88) begin
         // close to a multiple of p
         v = {256'd0, a} * {256'd0, PRIME};
         v = v + 512'($urandom_range(0, 4)) - 512'(2);
      end else begin
         // heavy upper limbs push the column sums negative
         v = {a, 256'd0};
         if ($urandom_range(0, 1)) v[3:0] = b;
      end
      return v;
   endfunction

   // response side: a shifting stall pattern plus the long hold-off on request
   initial begin : rsp_drain
      int unsigned tick;
      int holds_done;
      int mode;
      tick = 0;
      holds_done = 0;
      mode = 0;
      rsp_ch.ready = 1'b0;
      forever begin
         @(posedge clock);
         if (hold_requests != holds_done) begin
            holds_done++;
            rsp_ch.ready <= 1'b0;
            repeat (LONG_HOLD) @(posedge clock);
         end
         if (tick % 64 == 0) mode = $urandom_range(0, 3);
         case (mode)
            0:       rsp_ch.ready <= 1'b1;
            1:       rsp_ch.ready <= (tick % 4) != 3;
            2:       rsp_ch.ready <= 1'($urandom_range(0, 1));
            default: rsp_ch.ready <= (tick % 3) == 0;
         endcase
         tick++;
      end
   end

   initial begin : req_source
      wide_type directed_values [$];
      wide_type item;
      wide_type p_squared;
      int total;
      int burst_left;
      int gap;
      req_ch.valid = 1'b0;
      req_ch.wide_word0 = '0;
      req_ch.wide_word1 = '0;
      req_ch.wide_word2 = '0;
      req_ch.wide_word3 = '0;
      req_ch.wide_word4 = '0;
      req_ch.wide_word5 = '0;
      req_ch.wide_word6 = '0;
      req_ch.wide_word7 = '0;
      p_squared = {256'd0, PRIME} * {256'd0, PRIME};

      directed_values.push_back('0);
      directed_values.push_back(512'd1);
      directed_values.push_back({256'd0, PRIME} - 512'd1);
      directed_values.push_back({256'd0, PRIME});
      directed_values.push_back({256'd0, PRIME} + 512'd1);
      directed_values.push_back({256'd0, {256{1'b1}}});
      directed_values.push_back({255'd0, 1'b1, 256'd0});
      directed_values.push_back(p_squared - 512'd1);
      directed_values.push_back(p_squared);
      directed_values.push_back({512{1'b1}});
      directed_values.push_back(({256'd0, PRIME} - 512'd1) * ({256'd0, PRIME} - 512'd1));
      directed_values.push_back({{256{1'b1}}, 256'd0});
      directed_values.push_back({1'b1, 511'd0});
      directed_values.push_back({64{8'hAA}});
      directed_values.push_back({64{8'h55}});
      // limbs 11..14 only: the lowest column goes far below zero
      directed_values.push_back({32'd0, {4{32'hFFFFFFFF}}, 96'd0, 256'd0});
      // limbs 10..13 only: the top column goes negative
      directed_values.push_back({64'd0, 64'hFFFFFFFF_FFFFFFFF, 64'hFFFFFFFF_FFFFFFFF, 320'd0});
      directed_values.push_back({PRIME, 256'd0});
      directed_values.push_back({PRIME, PRIME});
      directed_values.push_back({32'hFFFFFFFF, 480'd0});
      total = directed_values.size() + RANDOM_COUNT;

      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      burst_left = $urandom_range(1, 40);
      for (int n = 0; n < total; n++) begin
         item = (n < directed_values.size()) ? directed_values[n] : random_request();
         if (n == HOLD_AT) hold_requests <= hold_requests + 1;
         if (n == DRAIN_AT) begin
            req_ch.valid <= 1'b0;
            @(posedge clock);
            while (sent_count != done_count) @(posedge clock);
         end
         req_ch.valid <= 1'b1;
         req_ch.wide_word0 <= item[0];
         req_ch.wide_word1 <= item[1];
         req_ch.wide_word2 <= item[2];
         req_ch.wide_word3 <= item[3];
         req_ch.wide_word4 <= item[4];
         req_ch.wide_word5 <= item[5];
         req_ch.wide_word6 <= item[6];
         req_ch.wide_word7 <= item[7];
         @(posedge clock);
         while (!req_ch.ready) @(posedge clock);
         burst_left--;
         if (burst_left == 0) begin
            gap = $urandom_range(1, 10);
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge clock);
            burst_left = $urandom_range(1, 40);
         end
      end
      req_ch.valid <= 1'b0;
      @(posedge clock);
      while (sent_count != done_count) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);

      if (expected_left != 0) $error("%0d responses never arrived", expected_left);
      if (error_count == 0 && expected_left == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule
